// ===== design/tac_pkg.sv =====
// Shared types and constants for the triple-angle cosine block.
// No dependencies; imported by tac_ctrl, tac_dpath and triple_angle_cosine.
`default_nettype none

package tac_pkg;

  localparam int unsigned AngleW = 32;
  localparam int unsigned LimitW = 25;

  // pi/2 in Q8.24, rounded to nearest
  localparam logic [32:0] HalfPiQ24  = 33'd26353589;
  // 0.01 in Q8.24
  localparam logic [LimitW-1:0] LimitReset = 25'd167772;
  // ceil(2^33 / 3): floor(n * DivRecip / 2^33) == floor(n / 3) for n < 2^32
  localparam logic [31:0] DivRecip   = 32'hAAAA_AAAB;

  typedef enum logic [1:0] {
    MUL_DIV3 = 2'd0,
    MUL_SQ   = 2'd1,
    MUL_CUBE = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;      // take a new angle from the input beat
    logic     mul;       // run the shared multiplier
    mul_sel_e mul_sel;
    logic     div_upd;   // magnitude <= product / 3
    logic     conv;      // reduced angle -> Q2.30
    logic     step_upd;  // s <= 3s - 4s^3
    logic     out_load;  // result into output register
  } tac_cmd_t;

  typedef struct packed {
    logic below;         // reduced magnitude under the small-angle limit
  } tac_sts_t;

endpackage

`default_nettype wire

// ===== design/tac_dpath.sv =====
// Datapath: angle register, shared 32x33 multiplier, recursion state, limit and
// output registers. Depends on tac_pkg; driven by tac_ctrl.
`default_nettype none

module tac_dpath import tac_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tac_cmd_t            cmd_i,
  output tac_sts_t                 sts_o,
  input  wire logic [AngleW-1:0]   angle_i,
  input  wire logic                cfg_we_i,
  input  wire logic [LimitW-1:0]   cfg_data_i,
  output logic      [AngleW-1:0]   cosine_o
);

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [LimitW-1:0] limit_q;
  logic              neg_q;
  logic [31:0]       mag_q, mag_d;
  logic [31:0]       s_q, s_d;
  logic [64:0]       prod_q, prod_d;
  logic [31:0]       cos_q;

  logic [32:0]       sum;
  logic [31:0]       m;
  logic [31:0]       mul_a;
  logic [32:0]       mul_b;
  logic [33:0]       cube;
  logic signed [39:0] conv_v, step_r, step_v;

  assign sum = {angle_i[AngleW-1], angle_i} + HalfPiQ24;
  assign m   = s_q[31] ? (32'd0 - s_q) : s_q;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_DIV3: begin
        mul_a = mag_q;
        mul_b = {1'b0, DivRecip};
      end
      MUL_SQ: begin
        mul_a = m;
        mul_b = {1'b0, m};
      end
      MUL_CUBE: begin
        mul_a = m;
        mul_b = prod_q[62:30];
      end
      default: begin
        mul_a = m;
        mul_b = {1'b0, m};
      end
    endcase
  end

  assign prod_d = 65'(mul_a) * 65'(mul_b);

  assign conv_v = signed'({2'b0, mag_q, 6'b0});
  assign cube   = prod_q[63:30];
  assign step_r = signed'(40'(m)) + signed'(40'({m, 1'b0})) - signed'(40'({cube, 2'b0}));
  assign step_v = s_q[31] ? -step_r : step_r;

  always_comb begin
    mag_d = mag_q;
    if (cmd_i.load) begin
      mag_d = sum[32] ? 32'(33'd0 - sum) : sum[31:0];
    end else if (cmd_i.div_upd) begin
      mag_d = prod_q[64:33];
    end
  end

  always_comb begin
    s_d = s_q;
    if (cmd_i.conv) begin
      s_d = sat32(neg_q ? -conv_v : conv_v);
    end else if (cmd_i.step_upd) begin
      s_d = sat32(step_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= sum[32];
    end
    mag_q <= mag_d;
    s_q   <= s_d;
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.out_load) begin
      cos_q <= s_q;
    end
  end

  assign sts_o.below = mag_q < {7'b0, limit_q};
  assign cosine_o    = cos_q;

endmodule

`default_nettype wire

// ===== design/tac_ctrl.sv =====
// Controller: sequences reduction, Q2.30 conversion, recursion steps and the
// output handshake. Depends on tac_pkg; commands tac_dpath.
`default_nettype none

module tac_ctrl import tac_pkg::*; #(
  parameter int unsigned MAX_REDUCTIONS = 12
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output tac_cmd_t      cmd_o,
  input  wire tac_sts_t sts_i
);

  localparam int unsigned CntW = $clog2(MAX_REDUCTIONS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REDUCTIONS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StDivU  = 3'd2;
  localparam logic [2:0] StConv  = 3'd3;
  localparam logic [2:0] StSq    = 3'd4;
  localparam logic [2:0] StCube  = 3'd5;
  localparam logic [2:0] StStepU = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '{mul_sel: MUL_DIV3, default: 1'b0};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (cnt_q != CntMax && !sts_i.below) begin
          cmd_o.mul = 1'b1;
          state_d   = StDivU;
        end else begin
          state_d = StConv;
        end
      end
      StDivU: begin
        cmd_o.div_upd = 1'b1;
        cnt_d         = cnt_q + CntOne;
        state_d       = StCheck;
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        state_d    = (cnt_q == '0) ? StDone : StSq;
      end
      StSq: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MUL_SQ;
        state_d       = StCube;
      end
      StCube: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_sel = MUL_CUBE;
        state_d       = StStepU;
      end
      StStepU: begin
        cmd_o.step_upd = 1'b1;
        cnt_d          = cnt_q - CntOne;
        state_d        = (cnt_q == CntOne) ? StDone : StSq;
      end
      StDone: begin
        // wait for the output register to free up
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

// ===== design/triple_angle_cosine.sv =====
// Channel   | dir | beat fields
// s_axis    | in  | tdata[31:0] angle, signed Q8.24
// m_axis    | out | tdata[31:0] cosine, signed Q2.30, saturated
// cfg       | in  | cfg_data_i[24:0] small_angle_limit, Q8.24 unsigned
//
// One item at a time: each reduction is a check that multiplies by 1/3 and an
// update, ending in a final check; each recursion step then runs square, cube
// and update states on the shared 32x33 multiplier.
// The output register holds a finished result while the next angle is taken.
// Reset clears the controller and loads the limit with 0.01; no clearing pass.
// Top level; depends on tac_pkg, tac_ctrl and tac_dpath.
`default_nettype none

module triple_angle_cosine import tac_pkg::*; #(
  parameter int unsigned MAX_REDUCTIONS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [AngleW-1:0]   s_axis_tdata,   // [31:0] angle
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [AngleW-1:0]   m_axis_tdata,   // [31:0] cosine
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [LimitW-1:0]   cfg_data_i      // [24:0] small_angle_limit
);

  tac_cmd_t cmd;
  tac_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tac_ctrl #(
    .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tac_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .angle_i   (s_axis_tdata),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .cosine_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== test/triple_angle_cosine_tb.sv =====
`timescale 1ns / 1ps
// Testbench for triple_angle_cosine: streams angle beats into the block, predicts each
// cosine in a scoreboard class and checks the output beats in order.
// Depends on tac_pkg and the triple_angle_cosine RTL.

module triple_angle_cosine_tb;
  import tac_pkg::*;

  localparam int unsigned MaxReductions = 12;
  localparam longint PiHalfQ24 = 64'sd26353589;
  localparam longint Q30Max = 64'sd2147483647;
  localparam longint Q30Min = -64'sd2147483648;
  localparam int DrainCycles = 80;
  localparam int CycleLimit = 1000000;
  localparam int RandPhases = 7;
  localparam int PhaseItems = 200;
  localparam logic [LimitW-1:0] LimitTop = '1;

  // edges of the default limit, full-scale inputs and the pi/2 offset
  localparam int DirDefault[15] = '{
    0, 1, -1, 2147483647, int'(32'h8000_0000),
    -26353589, -26353588, -26353590,
    -26353589 + 167771, -26353589 + 167772,
    -26353589 - 167771, -26353589 - 167772,
    26353589, int'(32'h5555_5555), int'(32'hAAAA_AAAA)
  };
  // limit of zero never stops the reduction
  localparam int DirZero[3] = '{0, -26353589, 2147483647};
  // widest limit: reduced angles on both sides of the limit; near 2 the recursion runs away and saturates
  localparam int DirWide[5] = '{
    7200841, -59908019, 7200842, 74309701, -127016879
  };

  class cosine_scoreboard;
    logic [LimitW-1:0] limit;
    logic [31:0]       cosine_q[$];
    int                mismatches;

    function new();
      limit = LimitReset;
      mismatches = 0;
    endfunction

    function void set_limit(logic [LimitW-1:0] v);
      limit = v;
    endfunction

    function longint sat_q30(longint v);
      if (v > Q30Max) return Q30Max;
      if (v < Q30Min) return Q30Min;
      return v;
    endfunction

    function logic [31:0] predict_cosine(logic [31:0] angle);
      longint      a;
      longint      s;
      longint      r;
      logic [63:0] m;
      logic [63:0] sq;
      logic [63:0] cube;
      int          n;
      bit          neg;
      a = longint'($signed(angle)) + PiHalfQ24;
      n = 0;
      while (n < MaxReductions && (a < 0 ? -a : a) >= longint'(limit)) begin
        a = a / 3;  // truncates toward zero
        n++;
      end
      s = sat_q30(a * 64);
      repeat (n) begin
        neg = s < 0;
        m = neg ? -s : s;
        sq = (m * m) >> 30;
        cube = (m * sq) >> 30;
        r = 3 * $signed(m) - 4 * $signed(cube);
        if (neg) r = -r;
        s = sat_q30(r);
      end
      return s[31:0];
    endfunction

    function void note_angle(logic [31:0] angle);
      cosine_q.push_back(predict_cosine(angle));
    endfunction

    function void check_cosine(logic [31:0] got);
      logic [31:0] want;
      if (cosine_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cosine beat: got %h", got);
        return;
      end
      want = cosine_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("cosine mismatch: expected %h got %h", want, got);
      end
    endfunction

    function int pending();
      return cosine_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [AngleW-1:0] s_axis_tdata = '0;   // [31:0] angle
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [AngleW-1:0] m_axis_tdata;        // [31:0] cosine
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i = '0;     // [24:0] small_angle_limit

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_hold = 0;

  cosine_scoreboard sb = new();

  triple_angle_cosine #(.MAX_REDUCTIONS(MaxReductions)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // output side: check each beat, then pick tready for the next edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_cosine(m_axis_tdata);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("triple_angle_cosine: mismatch");
    $finish;
  end

  task automatic send_angle(input logic [31:0] angle);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= angle;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_angle(angle);
  endtask

  // block is idle once every cosine is back and the last item has settled
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [31:0] random_angle(logic [LimitW-1:0] lim);
    longint off;
    longint r;
    case ($urandom_range(3))
      0, 1: return $urandom();
      2: begin
        // around -pi/2, where the limit decides how many divisions happen
        off = longint'($urandom_range(0, 4 * int'(lim) + 3));
        if ($urandom_range(1)) off = -off;
        r = off - PiHalfQ24;
        return r[31:0];
      end
      default: begin
        off = longint'($urandom_range(0, 32'h0400_0000));
        if ($urandom_range(1)) off = -off;
        return off[31:0];
      end
    endcase
  endfunction

  initial begin
    logic [LimitW-1:0] lim;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 75;
    foreach (DirDefault[i]) send_angle(DirDefault[i]);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_limit('0);
    foreach (DirZero[i]) send_angle(DirZero[i]);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    write_limit(LimitTop);
    foreach (DirWide[i]) send_angle(DirWide[i]);
    s_axis_tvalid <= 1'b0;
    wait_idle();

    for (int p = 0; p < RandPhases; p++) begin
      if (p < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 75;
      end else if (p < 5) begin
        send_idle_pct = 75;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: lim = 25'd1;
        1: lim = 25'd16777216;
        2: lim = LimitTop;
        3: lim = LimitReset;
        4: lim = 25'($urandom_range(1, 16777216));
        5: lim = 25'($urandom());
        default: lim = '0;
      endcase
      write_limit(lim);
      // long receiver stall so the output register fills and input backs up
      if (p == 1) rx_hold = 400;
      for (int i = 0; i < PhaseItems; i++) begin
        send_angle(random_angle(lim));
        if (p == 3 && i == PhaseItems / 2) begin
          s_axis_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b0;
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("triple_angle_cosine: match");
    end else begin
      $display("triple_angle_cosine: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tac_pkg.sv
design/tac_dpath.sv
design/tac_ctrl.sv
design/triple_angle_cosine.sv
test/triple_angle_cosine_tb.sv
